### design/gcb_pkg.sv
// Shared types and constants for the glyph coverage blitter.
`timescale 1ns / 1ps
`default_nettype none
package gcb_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned PitchW    = 14;
  localparam int unsigned IndexW    = 26;

  localparam logic [ColorW-1:0] FgReset    = 32'h00FF_FFFF;
  localparam logic [ColorW-1:0] BgReset    = 32'h0000_0000;
  localparam logic [PitchW-1:0] PitchReset = 14'd1024;

  localparam logic [ColorW-1:0] RedMask   = 32'h00FF_0000;
  localparam logic [ColorW-1:0] GreenMask = 32'h0000_FF00;
  localparam logic [ColorW-1:0] BlueMask  = 32'h0000_00FF;
  localparam logic [7:0]        FullCov   = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFgColor     = 3'd0,
    CfgBgColor     = 3'd1,
    CfgPitchWords  = 3'd2,
    CfgTransparent = 3'd3,
    CfgImmediate   = 3'd4
  } cfg_idx_e;

  // One computed framebuffer write, possibly repeated to the front buffer.
  typedef struct packed {
    logic [IndexW-1:0] word_index;
    logic [ColorW-1:0] pixel_value;
    logic              dual;
  } wr_t;

endpackage
`default_nettype wire

### design/gcb_blend.sv
// Per-channel coverage blend of foreground over background, divide by 255 exact.
`timescale 1ns / 1ps
`default_nettype none
module gcb_blend
  import gcb_pkg::*;
(
  input  wire logic [ColorW-1:0] fg_i,
  input  wire logic [ColorW-1:0] bg_i,
  input  wire logic [7:0]        cov_i,
  output      logic [ColorW-1:0] blend_o
);

  logic [7:0] cov_inv;
  logic [7:0] fg_ch [3];
  logic [7:0] bg_ch [3];
  logic [7:0] res_ch [3];

  assign cov_inv = FullCov - cov_i;

  assign fg_ch[2] = 8'((fg_i & RedMask) >> 16);
  assign fg_ch[1] = 8'((fg_i & GreenMask) >> 8);
  assign fg_ch[0] = 8'(fg_i & BlueMask);
  assign bg_ch[2] = 8'((bg_i & RedMask) >> 16);
  assign bg_ch[1] = 8'((bg_i & GreenMask) >> 8);
  assign bg_ch[0] = 8'(bg_i & BlueMask);

  for (genvar k = 0; k < 3; k++) begin : g_ch
    logic [15:0] prod_f;
    logic [15:0] prod_b;
    logic [16:0] sum;
    logic [16:0] quo;

    assign prod_f = 16'(fg_ch[k]) * 16'(cov_i);
    assign prod_b = 16'(bg_ch[k]) * 16'(cov_inv);
    assign sum    = {1'b0, prod_f} + {1'b0, prod_b};
    // floor(x/255) = (x + (x>>8) + 1) >> 8, exact for x up to 255*255
    assign quo    = sum + {8'b0, sum[16:8]} + 17'd1;
    assign res_ch[k] = quo[15:8];
  end

  assign blend_o = {8'h00, res_ch[2], res_ch[1], res_ch[0]};

endmodule
`default_nettype wire

### design/glyph_coverage_blit.sv
// Top level of the antialiased glyph coverage blitter.
`timescale 1ns / 1ps
`default_nettype none
// A header transaction (kind 0) loads the glyph origin, size, baseline and
// bearing; each pixel transaction (kind 1) steps a row-major position over
// the glyph, padding rows first, and produces one framebuffer write (two in
// immediate mode: back buffer, then front buffer), none outside the glyph or
// for background in transparent mode. One input transaction is taken per
// cycle unless the compute register is held full; the blend and the word
// index are computed in a single pass into the compute register, then move
// to the output register, so a new item is taken while a finished write
// waits. The single output port carries one write per cycle while out_ready_i
// is high; an immediate-mode pixel holds it for both writes, others pass at
// one per cycle. Config writes are always ready; unlisted indexes are ignored.
module glyph_coverage_blit
  import gcb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [11:0]        pos_x_i,
  input  wire logic [11:0]        pos_y_i,
  input  wire logic [7:0]         glyph_width_i,
  input  wire logic [7:0]         glyph_height_i,
  input  wire logic [7:0]         baseline_offset_i,
  input  wire logic signed [7:0]  x_bearing_i,
  input  wire logic [7:0]         coverage_i,

  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               to_front_o,
  output      logic [IndexW-1:0]  word_index_o,
  output      logic [ColorW-1:0]  pixel_value_o,
  output      logic               last_o
);

  // configuration registers
  logic [ColorW-1:0] fg_q, bg_q;
  logic [PitchW-1:0] pitch_q;
  logic              transp_q, immed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= FgReset;
      bg_q     <= BgReset;
      pitch_q  <= PitchReset;
      transp_q <= 1'b0;
      immed_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgFgColor:     fg_q     <= cfg_data_i;
        CfgBgColor:     bg_q     <= cfg_data_i;
        CfgPitchWords:  pitch_q  <= cfg_data_i[PitchW-1:0];
        CfgTransparent: transp_q <= cfg_data_i[0];
        CfgImmediate:   immed_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // glyph state
  logic [11:0] origin_x_q, origin_x_d;
  logic [11:0] origin_y_q, origin_y_d;
  logic [7:0]  cur_width_q, cur_width_d;
  logic [8:0]  total_rows_q, total_rows_d;
  logic [7:0]  pad_rows_q, pad_rows_d;
  logic [7:0]  bearing_q, bearing_d;
  logic [8:0]  row_count_q, row_count_d;
  logic [7:0]  col_count_q, col_count_d;

  // pipeline
  wr_t  p_q, p_d, o_q;
  logic p_valid_q, p_valid_d, o_valid_q, o_valid_d, o_beat_q, o_beat_d;
  logic o_done, p_move, in_accept;

  logic        active, is_bg, emit;
  logic [13:0] col_w;
  logic [12:0] col_sat;
  logic [12:0] row_w;
  logic [26:0] prod;
  logic [8:0]  col_inc;
  logic [7:0]  pad_calc;
  logic [ColorW-1:0] blend;

  gcb_blend u_blend (
    .fg_i   (fg_q),
    .bg_i   (bg_q),
    .cov_i  (coverage_i),
    .blend_o(blend)
  );

  assign o_done     = o_valid_q && out_ready_i && (!o_q.dual || o_beat_q);
  assign p_move     = p_valid_q && (!o_valid_q || o_done);
  assign in_ready_o = !p_valid_q || p_move;
  assign in_accept  = in_valid_i && in_ready_o;

  assign active = (cur_width_q != 8'd0) && (row_count_q < total_rows_q);
  assign is_bg  = (row_count_q < {1'b0, pad_rows_q}) || (coverage_i == 8'd0);
  assign emit   = active && !(is_bg && transp_q);

  // column = origin_x + bearing + col, negative saturates to 0
  assign col_w   = {2'b00, origin_x_q} + {{6{bearing_q[7]}}, bearing_q}
                 + {6'b0, col_count_q};
  assign col_sat = col_w[13] ? 13'd0 : col_w[12:0];
  assign row_w   = {1'b0, origin_y_q} + {4'b0, row_count_q};
  assign prod    = 27'(row_w) * 27'(pitch_q);
  assign col_inc = {1'b0, col_count_q} + 9'd1;

  assign pad_calc = (glyph_height_i > baseline_offset_i)
                  ? (glyph_height_i - baseline_offset_i) : 8'd0;

  always_comb begin
    origin_x_d   = origin_x_q;
    origin_y_d   = origin_y_q;
    cur_width_d  = cur_width_q;
    total_rows_d = total_rows_q;
    pad_rows_d   = pad_rows_q;
    bearing_d    = bearing_q;
    row_count_d  = row_count_q;
    col_count_d  = col_count_q;
    p_d          = p_q;
    p_valid_d    = p_valid_q && !p_move;

    if (in_accept) begin
      if (!kind_i) begin
        origin_x_d   = pos_x_i;
        origin_y_d   = pos_y_i;
        cur_width_d  = glyph_width_i;
        pad_rows_d   = pad_calc;
        total_rows_d = {1'b0, glyph_height_i} + {1'b0, pad_calc};
        bearing_d    = x_bearing_i;
        row_count_d  = 9'd0;
        col_count_d  = 8'd0;
      end else if (active) begin
        if (col_inc >= {1'b0, cur_width_q}) begin
          col_count_d = 8'd0;
          row_count_d = row_count_q + 9'd1;
        end else begin
          col_count_d = col_inc[7:0];
        end
        if (emit) begin
          p_valid_d         = 1'b1;
          p_d.word_index    = prod[IndexW-1:0] + {13'b0, col_sat};
          p_d.pixel_value   = is_bg ? bg_q : blend;
          p_d.dual          = immed_q;
        end
      end
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    o_beat_d  = o_beat_q;
    if (o_valid_q && out_ready_i) begin
      if (o_done) begin
        o_valid_d = 1'b0;
        o_beat_d  = 1'b0;
      end else begin
        o_beat_d  = 1'b1;
      end
    end
    if (p_move) begin
      o_valid_d = 1'b1;
      o_beat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      cur_width_q  <= '0;
      total_rows_q <= '0;
      pad_rows_q   <= '0;
      bearing_q    <= '0;
      row_count_q  <= '0;
      col_count_q  <= '0;
      p_valid_q    <= 1'b0;
      o_valid_q    <= 1'b0;
      o_beat_q     <= 1'b0;
    end else begin
      origin_x_q   <= origin_x_d;
      origin_y_q   <= origin_y_d;
      cur_width_q  <= cur_width_d;
      total_rows_q <= total_rows_d;
      pad_rows_q   <= pad_rows_d;
      bearing_q    <= bearing_d;
      row_count_q  <= row_count_d;
      col_count_q  <= col_count_d;
      p_valid_q    <= p_valid_d;
      o_valid_q    <= o_valid_d;
      o_beat_q     <= o_beat_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (p_move) begin
      o_q <= p_q;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign to_front_o    = o_beat_q;
  assign word_index_o  = o_q.word_index;
  assign pixel_value_o = o_q.pixel_value;
  assign last_o        = !o_q.dual || o_beat_q;

endmodule
`default_nettype wire

### tb/tb_glyph_coverage_blit.sv
// Self-checking testbench for the glyph coverage blitter with a prediction scoreboard.
`timescale 1ns / 1ps
module tb_glyph_coverage_blit;
  import gcb_pkg::*;

  localparam bit KindHeader = 1'b0;
  localparam bit KindPixel  = 1'b1;
  localparam bit BackBuf    = 1'b0;
  localparam bit FrontBuf   = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  localparam int IdlePct      = 25;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 300000;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 185;

  typedef struct packed {
    logic        kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  baseline_offset;
    logic [7:0]  x_bearing;
    logic [7:0]  coverage;
  } glyph_item_t;

  typedef struct packed {
    logic              to_front;
    logic [IndexW-1:0] word_index;
    logic [ColorW-1:0] pixel_value;
    logic              last;
  } fb_write_t;

  // Tracks glyph position and register state, predicts the framebuffer writes.
  class blit_scoreboard;
    logic [ColorW-1:0] fg, bg;
    logic [PitchW-1:0] pitch;
    logic              skip_bg, dual_write;
    logic [11:0]       org_x, org_y;
    logic [7:0]        cur_w, pad_rows, col_cnt;
    logic [8:0]        total_rows, row_cnt;
    logic signed [7:0] bearing;
    fb_write_t         pending_writes[$];
    int                errors, headers, drawn, checked, front_checked;

    function new();
      fg = FgReset;
      bg = BgReset;
      pitch = PitchReset;
      skip_bg = 1'b0;
      dual_write = 1'b0;
      org_x = '0;
      org_y = '0;
      cur_w = '0;
      pad_rows = '0;
      col_cnt = '0;
      total_rows = '0;
      row_cnt = '0;
      bearing = '0;
      errors = 0;
      headers = 0;
      drawn = 0;
      checked = 0;
      front_checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgFgColor:     fg = data;
        CfgBgColor:     bg = data;
        CfgPitchWords:  pitch = data[PitchW-1:0];
        CfgTransparent: skip_bg = data[0];
        CfgImmediate:   dual_write = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_channel(int unsigned f, int unsigned b, int unsigned a);
      return 8'((f * a + b * (FullCov - a)) / FullCov);
    endfunction

    function logic [ColorW-1:0] blend_word(int unsigned a);
      return {8'h00,
              mix_channel((fg & RedMask) >> 16, (bg & RedMask) >> 16, a),
              mix_channel((fg & GreenMask) >> 8, (bg & GreenMask) >> 8, a),
              mix_channel(fg & BlueMask, bg & BlueMask, a)};
    endfunction

    // Returns 1 when the item changed the glyph state (header or in-glyph pixel).
    function bit note_item(glyph_item_t it);
      logic [ColorW-1:0] value;
      logic              is_bg;
      int                col;
      int unsigned       row, lin;
      fb_write_t         wr;
      if (it.kind == KindHeader) begin
        org_x = it.pos_x;
        org_y = it.pos_y;
        cur_w = it.glyph_width;
        pad_rows = (it.glyph_height > it.baseline_offset) ?
                   it.glyph_height - it.baseline_offset : 8'd0;
        total_rows = it.glyph_height + pad_rows;
        bearing = it.x_bearing;
        row_cnt = '0;
        col_cnt = '0;
        headers++;
        return 1'b1;
      end
      if (cur_w == 0 || row_cnt >= total_rows) return 1'b0;
      is_bg = (row_cnt < pad_rows) || (it.coverage == 0);
      value = is_bg ? bg : blend_word(it.coverage);
      // keep the signed add separate so the bearing sign-extends
      col = int'(org_x);
      col = col + bearing;
      col = col + int'(col_cnt);
      if (col < 0) col = 0;
      row = org_y + row_cnt;
      lin = row * pitch + col;
      col_cnt = col_cnt + 1'b1;
      if (col_cnt >= cur_w) begin
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
      end
      drawn++;
      if (is_bg && skip_bg) return 1'b1;
      wr.to_front = BackBuf;
      wr.word_index = lin[IndexW-1:0];
      wr.pixel_value = value;
      wr.last = !dual_write;
      pending_writes.push_back(wr);
      if (dual_write) begin
        wr.to_front = FrontBuf;
        wr.last = 1'b1;
        pending_writes.push_back(wr);
      end
      return 1'b1;
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: index %0h value %08h", got.word_index, got.pixel_value);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      checked++;
      if (got.to_front == FrontBuf) front_checked++;
      if (got.to_front !== want.to_front) begin
        $error("to_front: expected %0d, got %0d", want.to_front, got.to_front);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0h, got %0h", want.word_index, got.word_index);
        errors++;
      end
      if (got.pixel_value !== want.pixel_value) begin
        $error("pixel_value: expected %08h, got %08h", want.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [11:0]        pos_x_i;
  logic [11:0]        pos_y_i;
  logic [7:0]         glyph_width_i;
  logic [7:0]         glyph_height_i;
  logic [7:0]         baseline_offset_i;
  logic signed [7:0]  x_bearing_i;
  logic [7:0]         coverage_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               to_front_o;
  logic [IndexW-1:0]  word_index_o;
  logic [ColorW-1:0]  pixel_value_o;
  logic               last_o;

  blit_scoreboard sb;
  int             cycles = 0;
  int             live_items = 0;
  int             accepted_items = 0;
  bit             no_idle = 1'b0;

  glyph_coverage_blit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check every accepted write, stall at random.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_write({to_front_o, word_index_o, pixel_value_o, last_o});
    out_ready_i <= no_idle || ($urandom_range(99, 0) >= IdlePct);
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("timeout after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic glyph_item_t header_item(int x, int y, int w, int h, int base,
                                              int bear);
    glyph_item_t it;
    it.kind = KindHeader;
    it.pos_x = 12'(x);
    it.pos_y = 12'(y);
    it.glyph_width = 8'(w);
    it.glyph_height = 8'(h);
    it.baseline_offset = 8'(base);
    it.x_bearing = 8'(bear);
    it.coverage = 8'($urandom);
    return it;
  endfunction

  // Header fields carry noise on pixel transactions.
  function automatic glyph_item_t pixel_item(logic [7:0] cov);
    glyph_item_t it;
    it.kind = KindPixel;
    it.pos_x = 12'($urandom);
    it.pos_y = 12'($urandom);
    it.glyph_width = 8'($urandom);
    it.glyph_height = 8'($urandom);
    it.baseline_offset = 8'($urandom);
    it.x_bearing = 8'($urandom);
    it.coverage = cov;
    return it;
  endfunction

  // Leaves valid high on return; the next call or wait_drain takes it from there.
  task automatic send_item(glyph_item_t it);
    if (!no_idle && $urandom_range(99, 0) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < IdlePct);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    pos_x_i <= it.pos_x;
    pos_y_i <= it.pos_y;
    glyph_width_i <= it.glyph_width;
    glyph_height_i <= it.glyph_height;
    baseline_offset_i <= it.baseline_offset;
    x_bearing_i <= it.x_bearing;
    coverage_i <= it.coverage;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    accepted_items++;
    if (sb.note_item(it)) live_items++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    // items that write nothing may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] fg, logic [31:0] bg, logic [31:0] pitch,
                              logic [31:0] skip, logic [31:0] dual, bit poke_unused);
    logic [CfgIdxW-1:0]  idx[6];
    logic [CfgDataW-1:0] val[6];
    int                  n;
    idx = '{CfgFgColor, CfgBgColor, CfgPitchWords, CfgTransparent, CfgImmediate,
            CfgUnused};
    val = '{fg, bg, pitch, skip, dual, $urandom};
    n = poke_unused ? 6 : 5;
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    logic [7:0] covs[9] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h33};
    // no header yet: nothing to draw
    send_item(pixel_item(8'hFF));
    // largest origin and size, baseline 0: all early rows are padding
    send_item(header_item(4095, 4095, 255, 255, 0, 127));
    send_item(pixel_item(8'hFF));
    send_item(pixel_item(8'h00));
    // left edge with most negative bearing: column clamps to 0
    send_item(header_item(0, 0, 3, 2, 1, -128));
    foreach (covs[k]) send_item(pixel_item(covs[k]));
    send_item(pixel_item(8'h55));
    // baseline past height: no padding rows
    send_item(header_item(100, 7, 1, 2, 200, 5));
    send_item(pixel_item(8'h01));
    send_item(pixel_item(8'hFE));
    // zero width, then zero height
    send_item(header_item(10, 10, 0, 5, 1, 0));
    send_item(pixel_item(8'h80));
    send_item(header_item(10, 10, 4, 0, 0, 0));
    send_item(pixel_item(8'h80));
  endtask

  task automatic run_glyphs(int budget, bit pause_midway);
    glyph_item_t hdr;
    int          start, steps, full, pad, roll;
    bit          paused, near_edge;
    logic [7:0]  cov;
    start = live_items;
    paused = 1'b0;
    while (live_items - start < budget) begin
      if (pause_midway && !paused && live_items - start >= budget / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      if ($urandom_range(99, 0) < 5) begin
        send_item(pixel_item(8'($urandom)));
        continue;
      end
      if ($urandom_range(99, 0) < 10) begin
        // full-range geometry, only a few pixels before the next header
        hdr = header_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        steps = $urandom_range(10, 1);
      end else begin
        near_edge = ($urandom_range(99, 0) < 15);
        hdr = header_item(near_edge ? $urandom_range(3, 0) : $urandom, $urandom,
                          $urandom_range(6, 1), $urandom_range(6, 0), 0, $urandom);
        hdr.baseline_offset = 8'($urandom_range(hdr.glyph_height + 2, 0));
        pad = (hdr.glyph_height > hdr.baseline_offset) ?
              hdr.glyph_height - hdr.baseline_offset : 0;
        full = hdr.glyph_width * (hdr.glyph_height + pad);
        roll = $urandom_range(99, 0);
        if (roll < 85) steps = full;
        else if (roll < 95) steps = $urandom_range(full, 0);
        else steps = full + $urandom_range(3, 1);
      end
      send_item(hdr);
      repeat (steps) begin
        roll = $urandom_range(99, 0);
        if (roll < 20) cov = 8'h00;
        else if (roll < 30) cov = FullCov;
        else cov = 8'($urandom_range(255, 0));
        send_item(pixel_item(cov));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFgColor;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KindHeader;
    pos_x_i = '0;
    pos_y_i = '0;
    glyph_width_i = '0;
    glyph_height_i = '0;
    baseline_offset_i = '0;
    x_bearing_i = '0;
    coverage_i = '0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    wait_drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: program_regs(32'hFFFF_FFFF, 32'h0, 32'd1, 32'h1, 32'h1, 1'b1);
        // junk above the used bits: pitch 8192, transparent on, immediate off
        1: program_regs(32'h0, 32'hFFFF_FFFF, 32'hFFFF_E000, 32'hFFFF_FFFF,
                        32'hFFFF_FFFE, 1'b0);
        2: program_regs($urandom, $urandom, 32'd0, 32'd0, 32'd0, 1'b0);
        3: program_regs($urandom, $urandom, 32'd16383, 32'd1, 32'd1, 1'b0);
        default: program_regs($urandom, $urandom, $urandom_range(8192, 1), $urandom,
                              $urandom, 1'b0);
      endcase
      no_idle = (p == 3);
      run_glyphs(PhaseItems, p == 4);
      wait_drain();
    end
    no_idle = 1'b0;

    if (sb.pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", sb.pending_writes.size());
      sb.errors++;
    end
    $display("stimulus: %0d transactions (%0d headers, %0d drawn pixels), %0d register setups",
             accepted_items, sb.headers, sb.drawn, NumPhases);
    $display("checked %0d framebuffer writes, %0d to the front buffer, %0d errors",
             sb.checked, sb.front_checked, sb.errors);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
design/gcb_pkg.sv
design/gcb_blend.sv
design/glyph_coverage_blit.sv
tb/tb_glyph_coverage_blit.sv
